@@ rtl/clwc_pkg.sv @@
package clwc_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W          = 32;
  localparam int KIND_W           = 3;
  localparam int COUNT_OUT_W      = 5;
  localparam int STATUS_W         = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 3'd0,
    KIND_REMOVE   = 3'd1,
    KIND_FORWARD  = 3'd2,
    KIND_BACKWARD = 3'd3,
    KIND_READ     = 3'd4,
    KIND_CLEAR    = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Shift command for the cell row. Cell 0 holds the cursor element, cell k
  // holds the element k steps behind it around the ring.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_RIGHT,
    CELL_LEFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wrap;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

@@ rtl/clwc_cell.sv @@
module clwc_cell
  import clwc_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [IDX_W-1:0]   tail_idx,
  input  logic [VALUE_W-1:0] from_left,
  input  logic [VALUE_W-1:0] from_right,
  input  logic [VALUE_W-1:0] wrap_value,
  output logic [VALUE_W-1:0] value
);

  logic is_tail;

  assign is_tail = (IDX_W'(IDX) == tail_idx);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_RIGHT: value <= from_left;
      CELL_LEFT:  value <= (ctl.wrap && is_tail) ? wrap_value : from_right;
      default:    value <= value;
    endcase
  end

endmodule

@@ rtl/clwc_ctrl.sv @@
module clwc_ctrl
  import clwc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      kind,
  input  logic [VALUE_W-1:0]     new_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_W-1:0]     cursor_value,
  output logic [COUNT_OUT_W-1:0] element_count,
  output logic [STATUS_W-1:0]    status,
  input  logic [VALUE_W-1:0]     cell_val [CAPACITY],
  output cell_ctl_t              cell_ctl,
  output logic [IDX_W-1:0]       tail_idx,
  output logic [VALUE_W-1:0]     head_value
);

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [KIND_W-1:0]    kind_q;
  logic [VALUE_W-1:0]   value_q;
  logic [VALUE_W-1:0]   tail_q;
  logic                 commit;
  logic                 empty, full;
  cell_op_t             op_next;
  logic                 wrap_next;
  status_t              status_next;
  logic [VALUE_W-1:0]   result_next;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(CAPACITY));
  assign tail_idx = IDX_W'(count - 1'b1);
  assign in_stall = (state != ST_IDLE);
  assign commit   = (state == ST_EXEC) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // item latch; tail is the successor of the cursor
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q  <= kind;
      value_q <= new_value;
      tail_q  <= cell_val[tail_idx];
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    op_next     = CELL_HOLD;
    wrap_next   = 1'b0;
    head_value  = value_q;
    status_next = STATUS_OK;
    result_next = cell_val[0];

    if (kind_q == KIND_INSERT) begin
      if (full) begin
        status_next = STATUS_FULL;
        result_next = empty ? '0 : cell_val[0];
      end else begin
        op_next     = CELL_RIGHT;
        count_next  = count + 1'b1;
        result_next = value_q;
      end
    end else if (empty) begin
      status_next = STATUS_EMPTY;
      result_next = '0;
    end else begin
      unique case (kind_q)
        KIND_REMOVE: begin
          op_next     = CELL_LEFT;
          count_next  = count - 1'b1;
          result_next = (count == CNT_W'(1)) ? '0 : cell_val[1];
        end
        KIND_FORWARD: begin
          op_next     = CELL_RIGHT;
          head_value  = tail_q;
          result_next = tail_q;
        end
        KIND_BACKWARD: begin
          op_next     = CELL_LEFT;
          wrap_next   = 1'b1;
          result_next = (count == CNT_W'(1)) ? cell_val[0] : cell_val[1];
        end
        KIND_CLEAR: begin
          count_next  = '0;
          result_next = '0;
        end
        default: begin
          result_next = cell_val[0];
        end
      endcase
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // nothing moves until the result can be registered
    if (!commit) begin
      count_next = count;
      op_next    = CELL_HOLD;
    end
  end

  assign cell_ctl = '{op: op_next, wrap: wrap_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      cursor_value  <= result_next;
      element_count <= COUNT_OUT_W'(count_next);
      status        <= status_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_EXEC))
    else $error("accepted beat did not start execution");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && kind_q == KIND_INSERT && !full) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the list");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (commit && count_next == '0) |=> (cursor_value == '0))
    else $error("empty list result carries a value");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (commit && status_next == STATUS_FULL) |-> full)
    else $error("full status on a list with room");
`endif

endmodule

@@ rtl/circular_list_with_cursor_top.sv @@
// Circular list with a cursor, up to CAPACITY signed 32-bit values.
// Input channel (in_valid/in_stall): kind selects insert, remove, forward,
// backward, read or clear; new_value is used by insert only. Codes 6 and 7
// act as read.
// Output channel (out_valid/out_stall): one result beat per input beat with
// the value at the cursor (zero when empty), the element count and a status
// (ok, empty list, full list with insert refused).
// Each item is handled in order: the beat and the tail element are latched,
// then the cell row shifts, where cell 0 holds the cursor element and the
// following cells hold its predecessors in order. The result beat is valid
// the cycle after execution. A new item is not taken while one executes;
// in_stall stays high from acceptance until the result is registered.
// The result sits in an output register; the next item is latched while it
// waits, and execution holds until the register frees up under out_stall.
// Reset empties the list; cell contents are not cleared and no beat is
// pending afterward.
module circular_list_with_cursor_top
  import clwc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      kind,
  input  logic [VALUE_W-1:0]     new_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_W-1:0]     cursor_value,
  output logic [COUNT_OUT_W-1:0] element_count,
  output logic [STATUS_W-1:0]    status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] cell_val   [CAPACITY];
  logic [VALUE_W-1:0] left_in    [CAPACITY];
  logic [VALUE_W-1:0] right_in   [CAPACITY];
  cell_ctl_t          cell_ctl;
  logic [IDX_W-1:0]   tail_idx;
  logic [VALUE_W-1:0] head_value;

  clwc_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .new_value     (new_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_value  (cursor_value),
    .element_count (element_count),
    .status        (status),
    .cell_val      (cell_val),
    .cell_ctl      (cell_ctl),
    .tail_idx      (tail_idx),
    .head_value    (head_value)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_in[g] = head_value;
    end else begin : g_body
      assign left_in[g] = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_inner
      assign right_in[g] = cell_val[g+1];
    end

    clwc_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .tail_idx   (tail_idx),
      .from_left  (left_in[g]),
      .from_right (right_in[g]),
      .wrap_value (cell_val[0]),
      .value      (cell_val[g])
    );
  end

endmodule
